FILE: design/kged_pkg.sv
// shared types, constants and codes of the key gesture event detector
package kged_pkg;

    localparam int KEYS_DEFAULT = 8;
    localparam int RAW_KEYS     = 8;

    typedef logic [31:0] t_time;
    typedef logic [7:0]  t_levels;
    typedef logic [2:0]  t_key_idx;
    typedef logic [1:0]  t_ev_code;
    typedef logic [2:0]  t_cfg_idx;
    typedef logic [15:0] t_cfg_data;

    localparam t_ev_code EV_SHORT  = 2'd0;
    localparam t_ev_code EV_DOUBLE = 2'd1;
    localparam t_ev_code EV_LONG   = 2'd2;
    localparam t_ev_code EV_REPEAT = 2'd3;

    localparam t_cfg_idx REG_SCAN_INTERVAL  = 3'd0;
    localparam t_cfg_idx REG_DEBOUNCE_COUNT = 3'd1;
    localparam t_cfg_idx REG_DCLICK_WINDOW  = 3'd2;
    localparam t_cfg_idx REG_LONG_TIME      = 3'd3;
    localparam t_cfg_idx REG_REPEAT_DELAY   = 3'd4;
    localparam t_cfg_idx REG_REPEAT_INTVL   = 3'd5;
    localparam t_cfg_idx REG_KEY_ENABLE     = 3'd6;

    localparam logic [15:0] RST_SCAN_INTERVAL  = 16'd10;
    localparam logic [7:0]  RST_DEBOUNCE_COUNT = 8'd3;
    localparam logic [15:0] RST_DCLICK_WINDOW  = 16'd300;
    localparam logic [15:0] RST_LONG_TIME      = 16'd1000;
    localparam logic [15:0] RST_REPEAT_DELAY   = 16'd500;
    localparam logic [15:0] RST_REPEAT_INTVL   = 16'd100;
    localparam logic [7:0]  RST_KEY_ENABLE     = 8'd0;

    localparam logic [1:0] CLICK_MAX = 2'd2;

    typedef struct packed {
        logic        stable;
        logic        pressed;
        logic [7:0]  bounce;
        t_time       press_time;
        t_time       release_time;
        logic        long_fired;
        logic [1:0]  click;
        logic        short_pending;
        logic        repeated;
        t_time       anchor;
    } t_key_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CALC_A,
        S_CALC_B,
        S_PUSH,
        S_FIN
    } t_state;

endpackage

FILE: design/kged_in_if.sv
// input channel: time stamp and raw key levels
interface kged_in_if import kged_pkg::*; ();
    logic    valid;
    logic    ready;
    t_time   now_time;
    t_levels raw_levels;

    modport source (output valid, output now_time, output raw_levels, input ready);
    modport sink   (input valid, input now_time, input raw_levels, output ready);
endinterface

FILE: design/kged_out_if.sv
// output channel: one key event per handshake
interface kged_out_if import kged_pkg::*; ();
    logic     valid;
    logic     ready;
    t_key_idx key_index;
    t_ev_code event_code;
    logic     last_event;

    modport source (output valid, output key_index, output event_code, output last_event,
                    input ready);
    modport sink   (input valid, input key_index, input event_code, input last_event,
                    output ready);
endinterface

FILE: design/key_gesture_event_detector_top.sv
// key gesture event detector: debounce, click, long press and repeat per key
//
//  channel   dir  handshake        payload
//  i_in      in   valid / ready    now_time[31:0], raw_levels[7:0]
//  o_out     out  valid / ready    key_index[2:0], event_code[1:0], last_event
//  i_cfg_*   in   write enable     i_cfg_idx[2:0], i_cfg_data[15:0]
//
// a request that arrives before the scan interval has passed is taken in S_IDLE and starts no scan
// a scanning request runs, for each key, a read, two compute steps and one push step
// on the state memory, and then a final step
// the push step repeats for each event; a stalled o_out holds the push and final steps
// after reset all per-key state reads as zero through valid bits, no clearing pass
module key_gesture_event_detector_top import kged_pkg::*; #(
    parameter int KEYS = KEYS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  t_cfg_idx  i_cfg_idx,
    input  t_cfg_data i_cfg_data,
    kged_in_if.sink   i_in,
    kged_out_if.source o_out
);

    localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(KEYS - 1);

    // configuration
    logic [15:0] r_scan, r_win, r_long, r_rdel, r_rint;
    logic [7:0]  r_dbc, r_ken;

    // control
    t_state        r_state, n_state;
    logic [KW-1:0] r_k, n_k;
    t_time         r_scan_ref, n_scan_ref;
    t_time         r_now, n_now;
    t_levels       r_raw, n_raw;

    // per-key working state
    t_key_state    r_mid, n_mid;
    logic [1:0]    r_ev_vld, n_ev_vld;
    t_ev_code      r_ev0, n_ev0;
    logic          r_hold_vld, n_hold_vld;
    t_ev_code      r_hold_code, n_hold_code;
    t_key_idx      r_hold_key, n_hold_key;
    logic          r_out_vld, n_out_vld;
    t_ev_code      r_out_code, n_out_code;
    t_key_idx      r_out_key, n_out_key;
    logic          r_out_last, n_out_last;

    // state memory
    t_key_state    r_mem [KEYS];
    logic [KEYS-1:0] r_vld;
    t_key_state    r_rd;
    logic          r_rd_vld;
    logic          w_mem_we;
    t_key_state    w_wdata;

    // helpers
    logic [5:0]  w_k6;
    t_key_idx    w_key;
    logic        w_in_range;
    logic        w_en;
    logic        w_level;
    t_key_state  w_cur;
    logic [7:0]  w_bc;
    t_time       w_d_rel, w_d_press, w_d_press_b;
    logic        w_rel_now;
    logic        w_short;
    t_ev_code    w_short_code;
    t_time       w_anchor_l;
    logic        w_long_fire, w_rep_l, w_rep_n, w_rep;
    t_time       w_need;
    logic        w_out_free;
    logic        w_sel;

    assign w_k6       = 6'(r_k);
    assign w_key      = w_k6[2:0];
    assign w_in_range = (w_k6 < 6'(RAW_KEYS));
    assign w_en       = w_in_range && r_ken[w_key];
    assign w_level    = w_in_range && r_raw[w_key];
    assign w_cur      = r_rd_vld ? r_rd : '0;
    assign w_out_free = !r_out_vld || o_out.ready;

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_vld;
    assign o_out.key_index  = r_out_key;
    assign o_out.event_code = r_out_code;
    assign o_out.last_event = r_out_last;

    // stage b time checks, from the registered stage a result
    assign w_d_press_b = r_now - r_mid.press_time;
    assign w_long_fire = r_mid.pressed && !r_mid.long_fired &&
                         (w_d_press_b >= 32'(r_long));
    assign w_anchor_l  = r_now + 32'(r_rdel);
    assign w_rep_l     = (r_now >= w_anchor_l) && ((r_now - w_anchor_l) >= 32'(r_rdel));
    assign w_need      = r_mid.repeated ? 32'(r_rint) : 32'(r_rdel);
    assign w_rep_n     = r_mid.pressed && r_mid.long_fired && (r_now >= r_mid.anchor) &&
                         ((r_now - r_mid.anchor) >= w_need);
    assign w_rep       = w_long_fire ? w_rep_l : w_rep_n;

    always_comb begin
        w_wdata = r_mid;
        if (w_long_fire) begin
            w_wdata.long_fired    = 1'b1;
            w_wdata.short_pending = 1'b0;
            w_wdata.click         = 2'd0;
            w_wdata.anchor        = w_anchor_l;
            w_wdata.repeated      = 1'b0;
        end
        if (w_rep) begin
            w_wdata.anchor   = r_now;
            w_wdata.repeated = 1'b1;
        end
    end

    assign w_mem_we = (r_state == S_CALC_B);

    // stage a: debounce, press / release edge, short press and double click
    always_comb begin
        n_mid        = w_cur;
        w_bc         = w_cur.bounce + 8'd1;
        w_d_rel      = r_now - w_cur.release_time;
        w_d_press    = r_now - w_cur.press_time;
        w_rel_now    = 1'b0;
        w_short      = 1'b0;
        w_short_code = EV_SHORT;
        if (w_level != w_cur.stable) begin
            if (w_bc >= r_dbc) begin
                n_mid.stable = w_level;
                n_mid.bounce = 8'd0;
            end else begin
                n_mid.bounce = w_bc;
            end
        end else begin
            n_mid.bounce = 8'd0;
        end
        if (n_mid.pressed != n_mid.stable) begin
            n_mid.pressed = n_mid.stable;
            if (n_mid.stable) begin
                n_mid.press_time = r_now;
                n_mid.long_fired = 1'b0;
                if (w_d_rel < 32'(r_win)) begin
                    n_mid.click = (w_cur.click < CLICK_MAX) ? w_cur.click + 2'd1 : CLICK_MAX;
                end else begin
                    n_mid.click = 2'd1;
                end
            end else begin
                n_mid.release_time = r_now;
                w_rel_now          = 1'b1;
                if (w_d_press < 32'(r_long)) begin
                    n_mid.short_pending = 1'b1;
                end
                n_mid.repeated = 1'b0;
                n_mid.anchor   = '0;
            end
        end
        // a release in this scan leaves zero time since release
        if (!n_mid.pressed && n_mid.short_pending &&
            ((w_rel_now ? 32'd0 : w_d_rel) >= 32'(r_win))) begin
            w_short             = 1'b1;
            w_short_code        = (n_mid.click >= CLICK_MAX) ? EV_DOUBLE : EV_SHORT;
            n_mid.short_pending = 1'b0;
            n_mid.click         = 2'd0;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_scan_ref  = r_scan_ref;
        n_now       = r_now;
        n_raw       = r_raw;
        n_ev_vld    = r_ev_vld;
        n_ev0       = r_ev0;
        n_hold_vld  = r_hold_vld;
        n_hold_code = r_hold_code;
        n_hold_key  = r_hold_key;
        n_out_vld   = r_out_vld && !o_out.ready;
        n_out_code  = r_out_code;
        n_out_key   = r_out_key;
        n_out_last  = r_out_last;
        w_sel       = !r_ev_vld[0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_now = i_in.now_time;
                    n_raw = i_in.raw_levels;
                    if ((i_in.now_time - r_scan_ref) >= 32'(r_scan)) begin
                        n_scan_ref = i_in.now_time;
                        n_k        = '0;
                        n_state    = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CALC_A;
            end
            S_CALC_A: begin
                n_ev_vld    = 2'b00;
                n_ev0       = w_short_code;
                n_ev_vld[0] = w_short && w_en;
                n_state     = S_CALC_B;
            end
            S_CALC_B: begin
                if (w_long_fire) begin
                    n_ev0       = EV_LONG;
                    n_ev_vld[0] = w_en;
                end
                n_ev_vld[1] = w_rep && w_en;
                n_state     = S_PUSH;
            end
            S_PUSH: begin
                if (r_ev_vld == 2'b00) begin
                    if (r_k == K_LAST) begin
                        n_state = S_FIN;
                    end else begin
                        n_k     = r_k + KW'(1);
                        n_state = S_READ;
                    end
                end else if (!r_hold_vld || w_out_free) begin
                    if (r_hold_vld) begin
                        // earlier event leaves, not the last of this request
                        n_out_vld  = 1'b1;
                        n_out_code = r_hold_code;
                        n_out_key  = r_hold_key;
                        n_out_last = 1'b0;
                    end
                    n_hold_vld      = 1'b1;
                    n_hold_code     = w_sel ? EV_REPEAT : r_ev0;
                    n_hold_key      = w_key;
                    n_ev_vld[w_sel] = 1'b0;
                end
            end
            S_FIN: begin
                if (!r_hold_vld) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_code = r_hold_code;
                    n_out_key  = r_hold_key;
                    n_out_last = 1'b1;
                    n_hold_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_scan_ref  <= '0;
            r_ev_vld    <= 2'b00;
            r_hold_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
            r_vld       <= '0;
            r_scan      <= RST_SCAN_INTERVAL;
            r_dbc       <= RST_DEBOUNCE_COUNT;
            r_win       <= RST_DCLICK_WINDOW;
            r_long      <= RST_LONG_TIME;
            r_rdel      <= RST_REPEAT_DELAY;
            r_rint      <= RST_REPEAT_INTVL;
            r_ken       <= RST_KEY_ENABLE;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_scan_ref  <= n_scan_ref;
            r_ev_vld    <= n_ev_vld;
            r_hold_vld  <= n_hold_vld;
            r_out_vld   <= n_out_vld;
            if (w_mem_we) begin
                r_vld[r_k] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SCAN_INTERVAL:  r_scan <= i_cfg_data;
                    REG_DEBOUNCE_COUNT: r_dbc  <= i_cfg_data[7:0];
                    REG_DCLICK_WINDOW:  r_win  <= i_cfg_data;
                    REG_LONG_TIME:      r_long <= i_cfg_data;
                    REG_REPEAT_DELAY:   r_rdel <= i_cfg_data;
                    REG_REPEAT_INTVL:   r_rint <= i_cfg_data;
                    REG_KEY_ENABLE:     r_ken  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_now       <= n_now;
        r_raw       <= n_raw;
        r_ev0       <= n_ev0;
        r_hold_code <= n_hold_code;
        r_hold_key  <= n_hold_key;
        r_out_code  <= n_out_code;
        r_out_key   <= n_out_key;
        r_out_last  <= n_out_last;
        if (r_state == S_CALC_A) begin
            r_mid <= n_mid;
        end
    end

    // per-key state memory, one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_k] <= w_wdata;
        end
        r_rd <= r_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[r_k];
        end
    end

endmodule

FILE: test/testbench.sv
// self-checking testbench for the key gesture event detector
`timescale 1ns / 1ps

module testbench;
    import kged_pkg::*;

    typedef struct packed {
        t_key_idx key;
        t_ev_code code;
        logic     last;
    } t_key_event;

    // mirrors the per-key gesture state and queues the events each request should cause
    class gesture_predictor;
        logic [15:0] scan_gap, dclick_win, hold_time, rep_delay, rep_step;
        logic [7:0]  bounce_limit, enable_mask;
        t_time       scan_ref;
        logic        stable     [RAW_KEYS];
        logic        pressed    [RAW_KEYS];
        logic [7:0]  bounce     [RAW_KEYS];
        t_time       t_press    [RAW_KEYS];
        t_time       t_release  [RAW_KEYS];
        logic        long_done  [RAW_KEYS];
        logic [1:0]  clicks     [RAW_KEYS];
        logic        short_wait [RAW_KEYS];
        logic        rep_seen   [RAW_KEYS];
        t_time       anchor     [RAW_KEYS];
        t_key_event  batch[$];
        t_key_event  pending_events[$];
        int          errors;

        function new();
            scan_gap     = RST_SCAN_INTERVAL;
            bounce_limit = RST_DEBOUNCE_COUNT;
            dclick_win   = RST_DCLICK_WINDOW;
            hold_time    = RST_LONG_TIME;
            rep_delay    = RST_REPEAT_DELAY;
            rep_step     = RST_REPEAT_INTVL;
            enable_mask  = RST_KEY_ENABLE;
            scan_ref     = '0;
            errors       = 0;
            for (int k = 0; k < RAW_KEYS; k++) begin
                stable[k]     = 1'b0;
                pressed[k]    = 1'b0;
                bounce[k]     = '0;
                t_press[k]    = '0;
                t_release[k]  = '0;
                long_done[k]  = 1'b0;
                clicks[k]     = '0;
                short_wait[k] = 1'b0;
                rep_seen[k]   = 1'b0;
                anchor[k]     = '0;
            end
        endfunction

        function void set_register(t_cfg_idx idx, t_cfg_data data);
            case (idx)
                REG_SCAN_INTERVAL:  scan_gap     = data;
                REG_DEBOUNCE_COUNT: bounce_limit = data[7:0];
                REG_DCLICK_WINDOW:  dclick_win   = data;
                REG_LONG_TIME:      hold_time    = data;
                REG_REPEAT_DELAY:   rep_delay    = data;
                REG_REPEAT_INTVL:   rep_step     = data;
                REG_KEY_ENABLE:     enable_mask  = data[7:0];
                default: ;
            endcase
        endfunction

        function void emit(int k, t_ev_code code);
            t_key_event ev;
            if (enable_mask[k] && batch.size() < 16) begin
                ev.key  = t_key_idx'(k);
                ev.code = code;
                ev.last = 1'b0;
                batch.push_back(ev);
            end
        endfunction

        function void note_request(t_time now, t_levels raw);
            t_time       elapsed;
            logic [15:0] need;
            batch.delete();
            // too early: nothing changes
            if (t_time'(now - scan_ref) < t_time'(scan_gap))
                return;
            scan_ref = now;
            for (int k = 0; k < RAW_KEYS; k++) begin
                if (raw[k] != stable[k]) begin
                    bounce[k] = bounce[k] + 8'd1;
                    if (bounce[k] >= bounce_limit) begin
                        stable[k] = raw[k];
                        bounce[k] = '0;
                    end
                end else begin
                    bounce[k] = '0;
                end

                if (pressed[k] != stable[k]) begin
                    pressed[k] = stable[k];
                    if (pressed[k]) begin
                        t_press[k]   = now;
                        long_done[k] = 1'b0;
                        if (t_time'(now - t_release[k]) < t_time'(dclick_win))
                            clicks[k] = (clicks[k] < 2'd2) ? clicks[k] + 2'd1 : 2'd2;
                        else
                            clicks[k] = 2'd1;
                    end else begin
                        t_release[k] = now;
                        if (t_time'(now - t_press[k]) < t_time'(hold_time))
                            short_wait[k] = 1'b1;
                        rep_seen[k] = 1'b0;
                        anchor[k]   = '0;
                    end
                end

                if (!pressed[k] && short_wait[k]
                    && t_time'(now - t_release[k]) >= t_time'(dclick_win)) begin
                    emit(k, (clicks[k] >= 2'd2) ? EV_DOUBLE : EV_SHORT);
                    short_wait[k] = 1'b0;
                    clicks[k]     = '0;
                end

                if (pressed[k] && !long_done[k]
                    && t_time'(now - t_press[k]) >= t_time'(hold_time)) begin
                    long_done[k]  = 1'b1;
                    short_wait[k] = 1'b0;
                    clicks[k]     = '0;
                    anchor[k]     = now + t_time'(rep_delay);
                    rep_seen[k]   = 1'b0;
                    emit(k, EV_LONG);
                end

                // plain unsigned compare against the anchor, no wrap handling
                if (pressed[k] && long_done[k] && now >= anchor[k]) begin
                    elapsed = now - anchor[k];
                    need    = rep_seen[k] ? rep_step : rep_delay;
                    if (elapsed >= t_time'(need)) begin
                        emit(k, EV_REPEAT);
                        anchor[k]   = now;
                        rep_seen[k] = 1'b1;
                    end
                end
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[j])
                pending_events.push_back(batch[j]);
        endfunction

        function void check_event(t_key_event got);
            t_key_event want;
            if (pending_events.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected event key %0d code %0d last %0b",
                             $time, got.key, got.code, got.last);
                return;
            end
            want = pending_events.pop_front();
            if (got.key !== want.key || got.code !== want.code || got.last !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: event mismatch, expected key %0d code %0d last %0b, ",
                              "got key %0d code %0d last %0b"},
                             $time, want.key, want.code, want.last,
                             got.key, got.code, got.last);
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_idx;
    t_cfg_data i_cfg_data;

    kged_in_if  in_ch ();
    kged_out_if out_ch ();

    gesture_predictor model;
    int accepted_items = 0;
    bit calm           = 1'b0;
    bit held_off       = 1'b0;
    int stall_left     = 0;

    key_gesture_event_detector_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic cfg_write(input t_cfg_idx idx, input t_cfg_data data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        model.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input t_cfg_data scan, input t_cfg_data deb,
                              input t_cfg_data dcw, input t_cfg_data hold,
                              input t_cfg_data rdelay, input t_cfg_data rstep,
                              input t_cfg_data mask);
        cfg_write(REG_SCAN_INTERVAL, scan);
        cfg_write(REG_DEBOUNCE_COUNT, deb);
        cfg_write(REG_DCLICK_WINDOW, dcw);
        cfg_write(REG_LONG_TIME, hold);
        cfg_write(REG_REPEAT_DELAY, rdelay);
        cfg_write(REG_REPEAT_INTVL, rstep);
        cfg_write(REG_KEY_ENABLE, mask);
    endtask

    task automatic send_request(input t_time now, input t_levels raw);
        int gap, r;
        @(negedge i_clk);
        in_ch.valid      <= 1'b1;
        in_ch.now_time   <= now;
        in_ch.raw_levels <= raw;
        do @(posedge i_clk); while (!in_ch.ready);
        model.note_request(now, raw);
        accepted_items++;
        r   = $urandom_range(0, 99);
        gap = calm ? 0 : (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(15, 60);
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
    endtask

    // drain: a scan with no events still keeps the block busy for a while
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (model.pending_events.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // keys held and released at random, with the odd glitch and time jump
    task automatic run_gestures(input int count, input t_time base, input int step_hi);
        t_levels held, glitch;
        t_time   t;
        int      r;
        held = '0;
        t    = base;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            for (int k = 0; k < RAW_KEYS; k++)
                if ($urandom_range(0, 15) == 0)
                    held[k] = ~held[k];
            glitch = ($urandom_range(0, 7) == 0) ? t_levels'(8'd1 << $urandom_range(0, 7)) : '0;
            if (r < 90) begin
                t = t + t_time'($urandom_range(0, step_hi));
                send_request(t, held ^ glitch);
            end else begin
                t = $urandom;
                send_request(t, t_levels'($urandom));
            end
        end
    endtask

    initial begin
        t_time   d_times [15] = '{200, 201, 202, 203, 204, 210, 226, 229, 232, 234,
                                  235, 245, 250, 252, 260};
        t_levels d_levels[15] = '{8'h0F, 8'h00, 8'h0F, 8'h00, 8'h30, 8'h30, 8'h30, 8'h30,
                                  8'h30, 8'h30, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00};
        model            = new();
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = REG_SCAN_INTERVAL;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.now_time   = '0;
        in_ch.raw_levels = '0;
        out_ch.ready     = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, all keys masked: early request, a scan just before the wrap, an early one just past it
        send_request(32'h0000_0000, 8'h00);
        send_request(32'hFFFF_FFFF, 8'hFF);
        send_request(32'h0000_0005, 8'h00);
        settle();

        // all timing settings zero, all keys enabled: every key flips at once and fires long press plus repeat together
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFF);
        send_request(32'd100, 8'hFF);
        send_request(32'd100, 8'hFF);
        send_request(32'd101, 8'h00);
        settle();

        // short press, double click, long press and repeats on a partial mask
        set_config(16'd1, 16'd1, 16'd6, 16'd20, 16'd3, 16'd2, 16'hA5);
        foreach (d_times[j])
            send_request(d_times[j], d_levels[j]);
        settle();

        set_config(16'hFFFF, 16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF);
        send_request(32'h0001_0200, 8'h55);
        send_request(32'h0001_0264, 8'hAA);
        settle();

        calm = 1'b1;
        set_config(16'd4, 16'd2, 16'd40, 16'd60, 16'd20, 16'd8, 16'hFF);
        run_gestures(75, $urandom, 8);
        settle();

        calm = 1'b0;
        // time stamps run through the wrap
        set_config(16'd1, 16'd1, 16'd12, 16'd25, 16'd0, 16'd3, 16'hFF);
        run_gestures(75, 32'hFFFF_FFA0, 3);
        settle();

        set_config(16'd0, 16'd3, 16'd8, 16'd15, 16'd5, 16'd0, 16'hFF);
        run_gestures(75, $urandom, 3);
        settle();

        repeat (2) begin
            set_config(t_cfg_data'($urandom_range(1, 8)), t_cfg_data'($urandom_range(1, 4)),
                       t_cfg_data'($urandom_range(10, 60)),
                       t_cfg_data'($urandom_range(20, 120)),
                       t_cfg_data'($urandom_range(0, 30)), t_cfg_data'($urandom_range(0, 15)),
                       t_cfg_data'($urandom_range(1, 255)));
            run_gestures(66, $urandom, 12);
            settle();
        end

        if (model.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // event side ready pacing, with one long hold-off once traffic is flowing
    initial begin : out_pacing
        int r;
        forever begin
            @(negedge i_clk);
            if (!held_off && accepted_items >= 200) begin
                held_off   = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (calm) begin
                out_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    out_ch.ready <= 1'b1;
                end else begin
                    out_ch.ready <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 50);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            model.check_event('{out_ch.key_index, out_ch.event_code, out_ch.last_event});
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
